// ===== src/csp_pkg.sv =====
// Shared types and constants for the checksummed sentence parser.
// Used by csp_front, csp_queue, csp_back and the top level; no dependencies.
package csp_pkg;

    // Character codes
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_UPPER_D = 8'h44;
    localparam logic [7:0] CH_UPPER_C = 8'h43;
    localparam logic [7:0] CH_UPPER_H = 8'h48;
    localparam logic [7:0] CH_UPPER_O = 8'h4F;

    localparam int          MAX_LEN_DEF     = 64;
    localparam int          QUEUE_DEPTH_DEF = 2;
    localparam int          FIELD_W         = 16;
    localparam int          NUM_FIELDS      = 3;
    localparam logic [2:0]  FIELD_IDX_SAT   = 3'd7;

    typedef enum logic [2:0] {
        PH_WAIT     = 3'd0,
        PH_PAYLOAD  = 3'd1,
        PH_SUM_HIGH = 3'd2,
        PH_SUM_LOW  = 3'd3,
        PH_NEWLINE  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_WAITING = 3'd0,
        ST_GOOD    = 3'd1,
        ST_FAIL    = 3'd2,
        ST_DET     = 3'd3,
        ST_CHA     = 3'd4,
        ST_HIT     = 3'd5,
        ST_COO     = 3'd6
    } t_status;

    // One classified character, as handed from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       is_dollar;
        logic       is_star;
        logic       is_comma;
        logic       is_newline;
        logic       is_digit;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_cls;

endpackage

// ===== src/csp_front.sv =====
// Front end: accepts received characters and classifies them into t_cls.
// Depends on csp_pkg.
module csp_front import csp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_in_stall,
    output logic       o_cls_valid,
    output t_cls       o_cls,
    input  logic       i_cls_stall
);

    logic r_valid;
    t_cls r_cls;
    t_cls n_cls;
    logic take;

    always_comb begin
        n_cls            = '0;
        n_cls.ch         = i_rx_byte;
        n_cls.is_dollar  = (i_rx_byte == CH_DOLLAR);
        n_cls.is_star    = (i_rx_byte == CH_STAR);
        n_cls.is_comma   = (i_rx_byte == CH_COMMA);
        n_cls.is_newline = (i_rx_byte == CH_NEWLINE);
        n_cls.is_digit   = (i_rx_byte >= 8'h30) && (i_rx_byte <= 8'h39);
        if (n_cls.is_digit) begin
            n_cls.hex_ok  = 1'b1;
            n_cls.hex_val = i_rx_byte[3:0];
        end else if ((i_rx_byte >= 8'h41) && (i_rx_byte <= 8'h46)) begin
            // uppercase A to F only
            n_cls.hex_ok  = 1'b1;
            n_cls.hex_val = 4'(i_rx_byte[3:0] + 4'd9);
        end
    end

    assign o_in_stall  = r_valid && i_cls_stall;
    assign take        = i_in_valid && !o_in_stall;
    assign o_cls_valid = r_valid;
    assign o_cls       = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (!i_cls_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ===== src/csp_queue.sv =====
// Short register queue of classified characters between front and back.
// Depends on csp_pkg.
module csp_queue import csp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_cls i_push_data,
    output logic o_push_stall,
    output logic o_pop_valid,
    output t_cls o_pop_data,
    input  logic i_pop_stall
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_stall = (r_count == CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && !o_push_stall;
    assign pop          = o_pop_valid && !i_pop_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (push && !pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (pop && !push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== src/csp_back.sv =====
// Back end: sentence state machine, checksum, field accumulation and result register.
// Depends on csp_pkg.
module csp_back import csp_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cls_valid,
    input  t_cls               i_cls,
    output logic               o_cls_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [FIELD_W-1:0] o_field_one,
    output logic [FIELD_W-1:0] o_field_two,
    output logic [FIELD_W-1:0] o_field_three
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    t_phase             r_phase, n_phase;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_sum, n_sum;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [2:0]         r_fidx, n_fidx;
    logic [7:0]         r_lead_first, n_lead_first;
    logic [7:0]         r_lead_second, n_lead_second;
    logic [FIELD_W-1:0] r_fval [NUM_FIELDS];
    logic [FIELD_W-1:0] n_fval [NUM_FIELDS];
    logic [NUM_FIELDS-1:0] r_fdone, n_fdone;

    logic               r_out_valid;
    t_status            r_status, n_status;
    logic [FIELD_W-1:0] r_f1, r_f2, r_f3, n_f1, n_f2, n_f3;

    logic               take;
    logic [FIELD_W+3:0] times_ten;
    logic [1:0]         fk;

    assign o_cls_stall = r_out_valid && i_out_stall;
    assign take        = i_cls_valid && !o_cls_stall;

    always_comb begin
        n_phase       = r_phase;
        n_xor         = r_xor;
        n_sum         = r_sum;
        n_count       = r_count;
        n_fidx        = r_fidx;
        n_lead_first  = r_lead_first;
        n_lead_second = r_lead_second;
        n_fval        = r_fval;
        n_fdone       = r_fdone;
        n_status      = ST_FAIL;
        n_f1          = '0;
        n_f2          = '0;
        n_f3          = '0;
        fk            = 2'(r_fidx[1:0] - 2'd1);
        times_ten     = ({4'd0, r_fval[fk]} << 3) + ({4'd0, r_fval[fk]} << 1)
                        + (FIELD_W+4)'(i_cls.ch[3:0]);

        case (r_phase)
            PH_WAIT: begin
                if (i_cls.is_dollar) begin
                    n_xor         = '0;
                    n_sum         = '0;
                    n_count       = '0;
                    n_fidx        = '0;
                    n_lead_first  = '0;
                    n_lead_second = '0;
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        n_fval[k] = '0;
                    end
                    n_fdone  = '0;
                    n_phase  = PH_PAYLOAD;
                    n_status = ST_GOOD;
                end else begin
                    n_status = ST_WAITING;
                end
            end
            PH_PAYLOAD: begin
                if (i_cls.is_star) begin
                    n_phase  = PH_SUM_HIGH;
                    n_status = ST_GOOD;
                end else if (r_count >= CNT_W'(MAX_LEN)) begin
                    n_phase  = PH_WAIT;
                    n_status = ST_FAIL;
                end else begin
                    n_status = ST_GOOD;
                    if (r_count == '0) begin
                        n_lead_first  = i_cls.ch;
                        n_lead_second = '0;
                    end else if (r_count == CNT_W'(1)) begin
                        n_lead_second = i_cls.ch;
                    end
                    n_count = CNT_W'(r_count + 1'b1);
                    n_xor   = r_xor ^ i_cls.ch;
                    if (i_cls.is_comma) begin
                        if (r_fidx != FIELD_IDX_SAT) begin
                            n_fidx = 3'(r_fidx + 3'd1);
                        end
                    end else if ((r_fidx != 3'd0) && (r_fidx <= 3'd3) && !r_fdone[fk]) begin
                        if (i_cls.is_digit) begin
                            // saturate at full scale
                            n_fval[fk] = (times_ten[FIELD_W+3:FIELD_W] != '0)
                                         ? '1 : times_ten[FIELD_W-1:0];
                        end else begin
                            n_fdone[fk] = 1'b1;
                        end
                    end
                end
            end
            PH_SUM_HIGH: begin
                if (!i_cls.hex_ok) begin
                    n_phase  = PH_WAIT;
                    n_status = ST_FAIL;
                end else begin
                    n_sum    = {i_cls.hex_val, 4'd0};
                    n_phase  = PH_SUM_LOW;
                    n_status = ST_GOOD;
                end
            end
            PH_SUM_LOW: begin
                if (!i_cls.hex_ok) begin
                    n_phase  = PH_WAIT;
                    n_status = ST_FAIL;
                end else begin
                    n_sum = {r_sum[7:4], i_cls.hex_val};
                    if ({r_sum[7:4], i_cls.hex_val} != r_xor) begin
                        n_phase  = PH_WAIT;
                        n_status = ST_FAIL;
                    end else begin
                        n_phase  = PH_NEWLINE;
                        n_status = ST_GOOD;
                    end
                end
            end
            PH_NEWLINE: begin
                n_phase = PH_WAIT;
                if (!i_cls.is_newline || (r_count == '0)) begin
                    n_status = ST_FAIL;
                end else if (r_lead_first == CH_UPPER_D) begin
                    n_status = ST_DET;
                end else if (r_lead_first == CH_UPPER_C) begin
                    n_status = ((r_count >= CNT_W'(2)) && (r_lead_second == CH_UPPER_O))
                               ? ST_COO : ST_CHA;
                end else if (r_lead_first == CH_UPPER_H) begin
                    n_status = ST_HIT;
                end else begin
                    n_status = ST_FAIL;
                end
                if ((n_status == ST_DET) || (n_status == ST_CHA) ||
                    (n_status == ST_HIT) || (n_status == ST_COO)) begin
                    n_f1 = r_fval[0];
                    n_f2 = r_fval[1];
                    if (n_status == ST_HIT) begin
                        n_f3 = r_fval[2];
                    end
                end
            end
            default: begin
                n_phase  = PH_WAIT;
                n_status = ST_FAIL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_WAIT;
            r_xor         <= '0;
            r_sum         <= '0;
            r_count       <= '0;
            r_fidx        <= '0;
            r_lead_first  <= '0;
            r_lead_second <= '0;
            for (int k = 0; k < NUM_FIELDS; k++) begin
                r_fval[k] <= '0;
            end
            r_fdone       <= '0;
        end else if (take) begin
            r_phase       <= n_phase;
            r_xor         <= n_xor;
            r_sum         <= n_sum;
            r_count       <= n_count;
            r_fidx        <= n_fidx;
            r_lead_first  <= n_lead_first;
            r_lead_second <= n_lead_second;
            r_fval        <= n_fval;
            r_fdone       <= n_fdone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status <= n_status;
            r_f1     <= n_f1;
            r_f2     <= n_f2;
            r_f3     <= n_f3;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_field_one   = r_f1;
    assign o_field_two   = r_f2;
    assign o_field_three = r_f3;

endmodule

// ===== src/checksummed_sentence_parser_unit.sv =====
// Checksummed sentence parser: one character per transfer in, one result per transfer out.
// Path: each character passes the front register, the queue and the result register in turn.
// Throughput: 1 character per cycle while no output stall or full queue holds the flow.
// Reset: synchronous active low; clears handshake state, queue pointers and the sentence state.
// Depends on csp_pkg, csp_front, csp_queue and csp_back.
module checksummed_sentence_parser_unit import csp_pkg::*; #(
    parameter int MAX_LEN     = MAX_LEN_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // character input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [FIELD_W-1:0] o_field_one,
    output logic [FIELD_W-1:0] o_field_two,
    output logic [FIELD_W-1:0] o_field_three
);

    // front to queue
    logic front_valid;
    t_cls front_cls;
    logic front_stall;

    // queue to back
    logic back_valid;
    t_cls back_cls;
    logic back_stall;

    // Classify each character as it arrives; hold it while the queue is full.
    csp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .o_in_stall  (o_in_stall),
        .o_cls_valid (front_valid),
        .o_cls       (front_cls),
        .i_cls_stall (front_stall)
    );

    // Decouple the two halves so a stalled result does not ripple straight to the input.
    csp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_data  (front_cls),
        .o_push_stall (front_stall),
        .o_pop_valid  (back_valid),
        .o_pop_data   (back_cls),
        .i_pop_stall  (back_stall)
    );

    // Advance the sentence state and register one result per character.
    csp_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cls_valid   (back_valid),
        .i_cls         (back_cls),
        .o_cls_stall   (back_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_field_one   (o_field_one),
        .o_field_two   (o_field_two),
        .o_field_three (o_field_three)
    );

endmodule
